// ----- src/btr_pkg.sv -----
`timescale 1ns / 1ps
// bitmap text renderer: shared types and constants
// used by btr_ctrl, btr_datapath and bitmap_text_renderer; no dependencies
package btr_pkg;

	localparam int CFG_W = 25;
	localparam int CFG_IDX_W = 3;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [12:0] COORD_CAP = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_IMAGE_WIDTH = 3'd2,
		REG_IMAGE_HEIGHT = 3'd3,
		REG_KERNING = 3'd4,
		REG_FG_COLOR = 3'd5,
		REG_BG_COLOR = 3'd6
	} reg_idx_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_DRAW = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic fetch;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic is_glyph;
		logic fetch_done;
		logic slot_free;
		logic pix_last;
	} dp_status_t;

endpackage

// ----- src/btr_ctrl.sv -----
`timescale 1ns / 1ps
// bitmap text renderer: sequencing state machine
// depends on btr_pkg
module btr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  btr_pkg::dp_status_t   sts,
	output btr_pkg::ctrl_cmd_t    cmd
);

	btr_pkg::state_t state_q;
	btr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btr_pkg::ST_CLEAR: begin
				if (sts.clear_done) state_d = btr_pkg::ST_IDLE;
			end
			btr_pkg::ST_IDLE: begin
				if (in_valid && sts.is_glyph) state_d = btr_pkg::ST_FETCH;
			end
			btr_pkg::ST_FETCH: begin
				if (sts.fetch_done) state_d = btr_pkg::ST_EMIT;
			end
			btr_pkg::ST_EMIT: begin
				if (sts.slot_free && sts.pix_last) state_d = btr_pkg::ST_IDLE;
			end
			default: state_d = btr_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			btr_pkg::ST_CLEAR: cmd.clear = 1'b1;
			btr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			btr_pkg::ST_FETCH: cmd.fetch = 1'b1;
			btr_pkg::ST_EMIT: cmd.emit = sts.slot_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- src/btr_datapath.sv -----
`timescale 1ns / 1ps
// bitmap text renderer: config registers, cursor, font memory,
// glyph row buffer, pixel counters and output register; depends on btr_pkg
module btr_datapath #(
	parameter int GLYPH_W = 8,
	parameter int GLYPH_H = 8,
	parameter int NUM_GLYPHS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  btr_pkg::ctrl_cmd_t             cmd,
	output btr_pkg::dp_status_t            sts,
	input  logic                           cfg_write,
	input  logic [btr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           command,
	input  logic [7:0]                     glyph_code,
	input  logic [2:0]                     glyph_row,
	input  logic [7:0]                     row_bits,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [11:0]                    pixel_x,
	output logic [11:0]                    pixel_y,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic                           write_enable,
	output logic                           last
);

	localparam int CODE_W = $clog2(NUM_GLYPHS);
	localparam int AW = CODE_W + 3;
	localparam int DEPTH = NUM_GLYPHS * 8;
	localparam int CW = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
	localparam int RW = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
	localparam int FW = $clog2(GLYPH_H + 1);

	function automatic logic [15:0] sat16(input logic [17:0] v);
		logic [15:0] r;
		if (!v[17] && (v[16:15] != 2'b00)) begin
			r = 16'h7FFF;
		end else if (v[17] && (v[16:15] != 2'b11)) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// configuration
	logic [12:0] origin_x_q, origin_y_q, width_q, height_q;
	logic [6:0]  kern_q;
	logic [24:0] fg_q, bg_q;

	logic [15:0] cursor_x_q, cursor_y_q;
	logic [CODE_W-1:0] code_q;

	// font memory
	logic [GLYPH_W-1:0] mem [DEPTH];
	logic [GLYPH_W-1:0] rd_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [GLYPH_W-1:0] wr_data;
	logic wr_en;

	logic [GLYPH_W-1:0] rows_q [GLYPH_H];
	logic [FW-1:0] fetch_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic out_valid_q;

	logic is_draw, code_in_range, is_glyph, load_ok, advance;
	logic [15:0] origin_x_ext, origin_y_ext;
	logic [15:0] next_x, next_y_nl;
	logic [12:0] wlim, hlim;
	logic [16:0] px, py;
	logic in_image, bit_set, we;
	logic [24:0] color;

	assign is_draw = (command == btr_pkg::CMD_DRAW);
	assign code_in_range = ({1'b0, glyph_code} < 9'(NUM_GLYPHS));
	assign is_glyph = is_draw && (glyph_code != 8'd0) &&
		(glyph_code != btr_pkg::NEWLINE_CODE) && code_in_range;
	assign load_ok = !is_draw && code_in_range && ({1'b0, glyph_row} < 4'(GLYPH_H));

	assign origin_x_ext = {{3{origin_x_q[12]}}, origin_x_q};
	assign origin_y_ext = {{3{origin_y_q[12]}}, origin_y_q};
	assign next_x = sat16({{2{cursor_x_q[15]}}, cursor_x_q} + 18'(GLYPH_W) +
		{{11{kern_q[6]}}, kern_q});
	assign next_y_nl = sat16({{2{cursor_y_q[15]}}, cursor_y_q} + 18'(GLYPH_H));

	assign sts.is_glyph = is_glyph;
	assign sts.clear_done = (clr_q == AW'(DEPTH - 1));
	assign sts.fetch_done = (fetch_q == FW'(GLYPH_H));
	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.pix_last = (col_q == CW'(GLYPH_W - 1)) && (row_q == RW'(GLYPH_H - 1));

	// code that draws nothing still moves the cursor on
	assign advance = (cmd.accept && is_draw && !is_glyph && (glyph_code != 8'd0) &&
		(glyph_code != btr_pkg::NEWLINE_CODE)) || (cmd.emit && sts.pix_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q <= 13'd640;
			height_q <= 13'd480;
			kern_q <= '0;
			fg_q <= '1;
			bg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				btr_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data[12:0];
				btr_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data[12:0];
				btr_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data[12:0];
				btr_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[12:0];
				btr_pkg::REG_KERNING: kern_q <= cfg_data[6:0];
				btr_pkg::REG_FG_COLOR: fg_q <= cfg_data;
				btr_pkg::REG_BG_COLOR: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (cfg_write && (cfg_index == btr_pkg::REG_ORIGIN_X)) begin
			cursor_x_q <= {{3{cfg_data[12]}}, cfg_data[12:0]};
		end else if (cfg_write && (cfg_index == btr_pkg::REG_ORIGIN_Y)) begin
			cursor_y_q <= {{3{cfg_data[12]}}, cfg_data[12:0]};
		end else if (cmd.accept && is_draw && (glyph_code == 8'd0)) begin
			cursor_x_q <= origin_x_ext;
			cursor_y_q <= origin_y_ext;
		end else if (cmd.accept && is_draw && (glyph_code == btr_pkg::NEWLINE_CODE)) begin
			cursor_x_q <= origin_x_ext;
			cursor_y_q <= next_y_nl;
		end else if (advance) begin
			cursor_x_q <= next_x;
		end
	end

	// memory ports: clearing pass or row load on the write side, row fetch on read
	assign wr_en = cmd.clear || (cmd.accept && load_ok);
	assign wr_addr = cmd.clear ? clr_q : {glyph_code[CODE_W-1:0], glyph_row};
	assign wr_data = cmd.clear ? '0 : row_bits[GLYPH_W-1:0];
	assign rd_addr = {code_q, 3'(fetch_q)};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) code_q <= glyph_code[CODE_W-1:0];
	end

	// read data shows in the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_q <= '0;
		end else if (cmd.fetch) begin
			fetch_q <= sts.fetch_done ? '0 : fetch_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch && (fetch_q != '0)) rows_q[RW'(fetch_q - FW'(1))] <= rd_q;
	end

	// column outer, row inner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.emit) begin
			if (row_q == RW'(GLYPH_H - 1)) begin
				row_q <= '0;
				col_q <= (col_q == CW'(GLYPH_W - 1)) ? '0 : col_q + CW'(1);
			end else begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	assign wlim = (width_q > btr_pkg::COORD_CAP) ? btr_pkg::COORD_CAP : width_q;
	assign hlim = (height_q > btr_pkg::COORD_CAP) ? btr_pkg::COORD_CAP : height_q;
	assign px = {cursor_x_q[15], cursor_x_q} + 17'(col_q);
	assign py = {cursor_y_q[15], cursor_y_q} + 17'(row_q);
	assign in_image = !px[16] && !py[16] && (px < 17'(wlim)) && (py < 17'(hlim));
	assign bit_set = rows_q[row_q][col_q];
	assign color = bit_set ? fg_q : bg_q;
	assign we = in_image && color[24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_x <= we ? px[11:0] : 12'd0;
			pixel_y <= we ? py[11:0] : 12'd0;
			red <= we ? color[23:16] : 8'd0;
			green <= we ? color[15:8] : 8'd0;
			blue <= we ? color[7:0] : 8'd0;
			write_enable <= we;
			last <= sts.pix_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/bitmap_text_renderer.sv -----
`timescale 1ns / 1ps
// flow: a load or a control code (end of string, newline, code out of range)
//   is taken while idle and needs no further work; a glyph is taken, then its rows
//   are fetched from the single-read font memory into the row buffer, then its
//   pixels go out one per cycle through the output register while out_ready allows;
//   in_ready stays low until the last pixel enters it. after reset the font memory
//   is cleared with in_ready low; config writes are taken throughout
module bitmap_text_renderer #(
	parameter int GLYPH_W = 8,
	parameter int GLYPH_H = 8,
	parameter int NUM_GLYPHS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [btr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btr_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [7:0]                     glyph_code,
	input  logic [2:0]                     glyph_row,
	input  logic [7:0]                     row_bits,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [11:0]                    pixel_x,
	output logic [11:0]                    pixel_y,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic                           write_enable,
	output logic                           last
);

	btr_pkg::ctrl_cmd_t cmd;
	btr_pkg::dp_status_t sts;

	btr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	btr_datapath #(
		.GLYPH_W    (GLYPH_W),
		.GLYPH_H    (GLYPH_H),
		.NUM_GLYPHS (NUM_GLYPHS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.glyph_code   (glyph_code),
		.glyph_row    (glyph_row),
		.row_bits     (row_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.write_enable (write_enable),
		.last         (last)
	);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// testbench for bitmap_text_renderer: font loads and character draws checked pixel by pixel
// against a pixel predictor kept in this file; depends on btr_pkg and bitmap_text_renderer
module tb;

	localparam int GLYPH_W = 8;
	localparam int GLYPH_H = 8;
	localparam int NUM_GLYPHS = 256;
	localparam logic [7:0] END_CODE = 8'd0;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER = 500;
	localparam longint CYCLE_LIMIT = 64'd10_000_000;

	typedef struct {
		btr_pkg::command_t cmd;
		logic [7:0] code;
		logic [2:0] row;
		logic [7:0] bits;
	} text_req_t;

	typedef struct packed {
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic we;
		logic is_last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [btr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [btr_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic [7:0] glyph_code = '0;
	logic [2:0] glyph_row = '0;
	logic [7:0] row_bits = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic write_enable;
	logic last;

	bitmap_text_renderer #(
		.GLYPH_W(GLYPH_W),
		.GLYPH_H(GLYPH_H),
		.NUM_GLYPHS(NUM_GLYPHS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.glyph_code(glyph_code),
		.glyph_row(glyph_row),
		.row_bits(row_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue),
		.write_enable(write_enable),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: registers, cursor and font memory
	int org_x, org_y, cur_x, cur_y, kern;
	logic [12:0] img_w, img_h;
	logic [24:0] fg_col, bg_col;
	logic [7:0] font_mem [2048];

	text_req_t req_q[$];
	pixel_t pixel_q[$];
	logic [7:0] glyph_pool[$];

	text_req_t cur_req;
	logic next_valid, next_ready;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int pix_seen = 0;
	int idle_pct = 0;
	int err_cnt = 0;
	longint cycle_cnt = 0;

	function automatic int sat16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void set_reg(btr_pkg::reg_idx_t idx, logic [24:0] v);
		case (idx)
			btr_pkg::REG_ORIGIN_X: begin
				org_x = $signed(v[12:0]);
				cur_x = org_x;
			end
			btr_pkg::REG_ORIGIN_Y: begin
				org_y = $signed(v[12:0]);
				cur_y = org_y;
			end
			btr_pkg::REG_IMAGE_WIDTH: img_w = v[12:0];
			btr_pkg::REG_IMAGE_HEIGHT: img_h = v[12:0];
			btr_pkg::REG_KERNING: kern = $signed(v[6:0]);
			btr_pkg::REG_FG_COLOR: fg_col = v;
			btr_pkg::REG_BG_COLOR: bg_col = v;
			default: ;
		endcase
	endfunction

	// apply one accepted request and queue the pixels it should produce
	function automatic void render(text_req_t rq);
		int wlim, hlim, x, y, i, j;
		logic [24:0] col;
		pixel_t p;
		if (rq.cmd == btr_pkg::CMD_LOAD) begin
			font_mem[{rq.code, rq.row}] = rq.bits;
			return;
		end
		if (rq.code == END_CODE) begin
			cur_x = org_x;
			cur_y = org_y;
			return;
		end
		if (rq.code == btr_pkg::NEWLINE_CODE) begin
			cur_x = org_x;
			cur_y = sat16(cur_y + GLYPH_H);
			return;
		end
		wlim = (img_w < btr_pkg::COORD_CAP) ? int'(img_w) : int'(btr_pkg::COORD_CAP);
		hlim = (img_h < btr_pkg::COORD_CAP) ? int'(img_h) : int'(btr_pkg::COORD_CAP);
		// column order, top to bottom inside each column
		for (i = 0; i < GLYPH_W; i++) begin
			for (j = 0; j < GLYPH_H; j++) begin
				col = font_mem[{rq.code, 3'(j)}][i] ? fg_col : bg_col;
				x = cur_x + i;
				y = cur_y + j;
				p = '0;
				if (x >= 0 && y >= 0 && x < wlim && y < hlim && col[24]) begin
					p.px = x[11:0];
					p.py = y[11:0];
					p.r = col[23:16];
					p.g = col[15:8];
					p.b = col[7:0];
					p.we = 1'b1;
				end
				p.is_last = (i == GLYPH_W - 1) && (j == GLYPH_H - 1);
				pixel_q.push_back(p);
			end
		end
		cur_x = sat16(cur_x + GLYPH_W + kern);
	endfunction

	function automatic void cmp_field(string name, int expv, int gotv);
		if (expv != gotv) begin
			err_cnt++;
			$display("%0t: %s expected %0d, got %0d", $time, name, expv, gotv);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= btr_pkg::CMD_LOAD;
			glyph_code <= '0;
			glyph_row <= '0;
			row_bits <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				render(cur_req);
				next_valid = 1'b0;
			end else begin
				next_valid = in_valid;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
					send_gap = $urandom_range(0, 17);
				end else if (req_q.size() > 0) begin
					cur_req = req_q.pop_front();
					command <= cur_req.cmd;
					glyph_code <= cur_req.code;
					glyph_row <= cur_req.row;
					row_bits <= cur_req.bits;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// pixel monitor and output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				pix_seen++;
				if (pixel_q.size() == 0) begin
					err_cnt++;
					$display("%0t: pixel with nothing expected, x %0d y %0d",
						$time, pixel_x, pixel_y);
				end else begin
					pixel_t want;
					want = pixel_q.pop_front();
					cmp_field("pixel_x", want.px, pixel_x);
					cmp_field("pixel_y", want.py, pixel_y);
					cmp_field("red", want.r, red);
					cmp_field("green", want.g, green);
					cmp_field("blue", want.b, blue);
					cmp_field("write_enable", want.we, write_enable);
					cmp_field("last", want.is_last, last);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (!hold_done && pix_seen >= HOLD_AFTER) begin
				// long hold so the renderer backs up into its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 17);
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			out_ready <= next_ready;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[bitmap_text_renderer] ERROR");
			$finish;
		end
	end

	task automatic push_load(logic [7:0] code, logic [2:0] row, logic [7:0] bits);
		text_req_t rq;
		rq.cmd = btr_pkg::CMD_LOAD;
		rq.code = code;
		rq.row = row;
		rq.bits = bits;
		req_q.push_back(rq);
	endtask

	// row and bits are don't-care for a draw, filled with noise
	task automatic push_draw(logic [7:0] code);
		text_req_t rq;
		rq.cmd = btr_pkg::CMD_DRAW;
		rq.code = code;
		rq.row = 3'($urandom);
		rq.bits = 8'($urandom);
		req_q.push_back(rq);
	endtask

	task automatic push_glyph(logic [7:0] code);
		int r;
		for (r = 0; r < GLYPH_H; r++)
			push_load(code, 3'(r), 8'($urandom));
		glyph_pool.push_back(code);
	endtask

	function automatic logic [7:0] pick_code();
		return glyph_pool[$urandom_range(0, glyph_pool.size() - 1)];
	endfunction

	task automatic write_reg(btr_pkg::reg_idx_t idx, logic [24:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		set_reg(idx, v);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait until every request is taken and every pixel is back, then let the block drain
	task automatic settle();
		do
			@(negedge clk);
		while (req_q.size() != 0 || in_valid || pixel_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly whole glyph loads followed by draws, with stray loads and control codes
	task automatic random_items(int n);
		int k, r;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				push_glyph(8'($urandom_range(1, 255)));
				k += GLYPH_H;
			end else begin
				if (r < 22)
					push_load(8'($urandom), 3'($urandom), 8'($urandom));
				else if (r < 30)
					push_draw(btr_pkg::NEWLINE_CODE);
				else if (r < 34)
					push_draw(END_CODE);
				else if (r < 40)
					push_draw(8'($urandom));
				else
					push_draw(pick_code());
				k++;
			end
		end
	endtask

	task automatic random_config();
		write_reg(btr_pkg::REG_ORIGIN_X, 25'($urandom_range(0, 1) ?
			$urandom_range(0, 660) - 20 : $urandom_range(0, 8191)));
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'($urandom_range(0, 1) ?
			$urandom_range(0, 500) - 20 : $urandom_range(0, 8191)));
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'($urandom_range(0, 3) == 0 ?
			$urandom_range(0, 8191) : $urandom_range(1, 700)));
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'($urandom_range(0, 3) == 0 ?
			$urandom_range(0, 8191) : $urandom_range(1, 500)));
		write_reg(btr_pkg::REG_KERNING, 25'($urandom_range(0, 127)));
		write_reg(btr_pkg::REG_FG_COLOR, {$urandom_range(0, 3) != 0, 24'($urandom)});
		write_reg(btr_pkg::REG_BG_COLOR, {$urandom_range(0, 2) == 0, 24'($urandom)});
	endtask

	initial begin
		int n;
		org_x = 0;
		org_y = 0;
		cur_x = 0;
		cur_y = 0;
		kern = 0;
		img_w = 13'd640;
		img_h = 13'd480;
		fg_col = 25'h1FFFFFF;
		bg_col = '0;
		for (n = 0; n < 2048; n++)
			font_mem[n] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty font, full glyph load, both code extremes, newline, end of string
		idle_pct = 10;
		push_draw(8'd65);
		push_load(8'd65, 3'd0, 8'hFF);
		push_load(8'd65, 3'd1, 8'h81);
		push_load(8'd65, 3'd2, 8'h42);
		push_load(8'd65, 3'd3, 8'h24);
		push_load(8'd65, 3'd4, 8'h18);
		push_load(8'd65, 3'd5, 8'h00);
		push_load(8'd65, 3'd6, 8'h7E);
		push_load(8'd65, 3'd7, 8'h01);
		push_load(8'd255, 3'd7, 8'hA5);
		push_load(8'd1, 3'd0, 8'h80);
		push_draw(8'd65);
		push_draw(8'd255);
		push_draw(btr_pkg::NEWLINE_CODE);
		push_draw(8'd1);
		push_draw(8'd65);
		push_draw(END_CODE);
		push_draw(8'd65);
		glyph_pool.push_back(8'd65);
		glyph_pool.push_back(8'd255);
		glyph_pool.push_back(8'd1);
		settle();

		// text clipped at the left and top edges, both colors on
		write_reg(btr_pkg::REG_ORIGIN_X, 25'(-5));
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'(-3));
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'd640);
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'd480);
		write_reg(btr_pkg::REG_KERNING, 25'd0);
		write_reg(btr_pkg::REG_FG_COLOR, 25'h1FF0000);
		write_reg(btr_pkg::REG_BG_COLOR, 25'h100FF00);
		random_items(70);
		settle();

		// far corner of the largest image, foreground disabled
		write_reg(btr_pkg::REG_ORIGIN_X, 25'd4095);
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'd4088);
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'd4096);
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'd4096);
		write_reg(btr_pkg::REG_KERNING, 25'd63);
		write_reg(btr_pkg::REG_FG_COLOR, 25'h0ABCDEF);
		write_reg(btr_pkg::REG_BG_COLOR, 25'h1FFFFFF);
		idle_pct = 0;
		random_items(30);
		settle();

		// zero sized image clips everything
		write_reg(btr_pkg::REG_ORIGIN_X, 25'(-4096));
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'(-4096));
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'd0);
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'd0);
		write_reg(btr_pkg::REG_KERNING, 25'(-64));
		write_reg(btr_pkg::REG_FG_COLOR, 25'h1FFFFFF);
		idle_pct = 25;
		random_items(20);
		settle();

		// sizes above the coordinate cap
		write_reg(btr_pkg::REG_ORIGIN_X, 25'd4080);
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'd4090);
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'd8191);
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'd8191);
		write_reg(btr_pkg::REG_KERNING, 25'(-8));
		write_reg(btr_pkg::REG_FG_COLOR, 25'h1000000);
		write_reg(btr_pkg::REG_BG_COLOR, 25'h1FFFFFF);
		idle_pct = 5;
		random_items(30);
		settle();

		// single pixel image
		write_reg(btr_pkg::REG_ORIGIN_X, 25'd0);
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'(-2));
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'd1);
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'd1);
		write_reg(btr_pkg::REG_KERNING, 25'd1);
		idle_pct = 15;
		random_items(20);
		settle();

		for (n = 0; n < 5; n++) begin
			random_config();
			case (n % 4)
				0: idle_pct = 0;
				1: idle_pct = 5;
				2: idle_pct = 15;
				default: idle_pct = 30;
			endcase
			random_items(40);
			settle();
		end

		// closing stretch at full rate
		idle_pct = 0;
		write_reg(btr_pkg::REG_ORIGIN_X, 25'd3);
		write_reg(btr_pkg::REG_ORIGIN_Y, 25'd5);
		write_reg(btr_pkg::REG_IMAGE_WIDTH, 25'd640);
		write_reg(btr_pkg::REG_IMAGE_HEIGHT, 25'd480);
		write_reg(btr_pkg::REG_KERNING, 25'd2);
		write_reg(btr_pkg::REG_FG_COLOR, 25'h1C0FFEE);
		write_reg(btr_pkg::REG_BG_COLOR, 25'h1102030);
		random_items(40);
		settle();

		if (err_cnt == 0)
			$display("[bitmap_text_renderer] OK");
		else
			$display("[bitmap_text_renderer] ERROR");
		$finish;
	end

endmodule
